// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // Register index of the enable register.
  localparam logic REG_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_START  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic {
    KIND_STATUS   = 1'b0,
    KIND_DISPATCH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_ENTRY,
    S_FINAL
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  priority_req;
    logic [15:0] initial_count;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] task_id_out;
    status_e    status;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [15:0] counter;
    logic [7:0]  prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    do_insert;
    logic    do_remove;
    logic    tick_update;
    logic    set_started;
    logic    out_load;
    kind_e   out_kind;
    status_e out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e req_cmd;
    logic id_null;
    logic count_zero;
    logic full;
    logic idx_end;
    logic prio_ge;
    logic id_match;
    logic tick_hit;
    logic started;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/pts_ctrl.sv =====
module pts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               enable_i,
  input  pts_pkg::dp_status_t sts_i,
  output pts_pkg::dp_cmd_t   cmd_o
);

  pts_pkg::state_e  state_q, state_d;
  pts_pkg::status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pts_pkg::S_IDLE;
      status_q <= pts_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // Next state and the closing status code.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = pts_pkg::S_DECODE;
        end
      end
      pts_pkg::S_DECODE: begin
        status_d = pts_pkg::ST_OK;
        state_d  = pts_pkg::S_FINAL;
        case (sts_i.req_cmd)
          pts_pkg::CMD_CREATE: begin
            if (sts_i.id_null) begin
              status_d = pts_pkg::ST_NULL;
            end else if (!enable_i) begin
              status_d = pts_pkg::ST_DISABLED;
            end else if (sts_i.full) begin
              status_d = pts_pkg::ST_FULL;
            end else begin
              state_d = pts_pkg::S_SEARCH;
            end
          end
          pts_pkg::CMD_DELETE: begin
            if (sts_i.id_null) begin
              status_d = pts_pkg::ST_NULL;
            end else if (sts_i.count_zero) begin
              status_d = pts_pkg::ST_EMPTY;
            end else begin
              state_d = pts_pkg::S_SEARCH;
            end
          end
          pts_pkg::CMD_START: begin
            if (!enable_i) begin
              status_d = pts_pkg::ST_DISABLED;
            end else begin
              state_d = pts_pkg::S_ENTRY;
            end
          end
          default: begin
            if (sts_i.started) begin
              state_d = pts_pkg::S_ENTRY;
            end
          end
        endcase
      end
      pts_pkg::S_SEARCH: begin
        if (sts_i.req_cmd == pts_pkg::CMD_CREATE) begin
          if (sts_i.idx_end || !sts_i.prio_ge) begin
            state_d = pts_pkg::S_FINAL;
          end
        end else begin
          if (sts_i.idx_end) begin
            status_d = pts_pkg::ST_NOT_FOUND;
            state_d  = pts_pkg::S_FINAL;
          end else if (sts_i.id_match) begin
            state_d = pts_pkg::S_FINAL;
          end
        end
      end
      pts_pkg::S_ENTRY: begin
        if (sts_i.idx_end) begin
          state_d = pts_pkg::S_FINAL;
        end
      end
      pts_pkg::S_FINAL: begin
        if (sts_i.out_free) begin
          state_d = pts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pts_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_kind   = pts_pkg::KIND_STATUS;
    cmd_o.out_status = pts_pkg::ST_OK;
    in_stall_o       = (state_q != pts_pkg::S_IDLE);
    case (state_q)
      pts_pkg::S_IDLE: begin
        cmd_o.load_req = in_valid_i;
      end
      pts_pkg::S_DECODE: begin
        cmd_o.idx_clr = 1'b1;
      end
      pts_pkg::S_SEARCH: begin
        if (sts_i.req_cmd == pts_pkg::CMD_CREATE) begin
          if (sts_i.idx_end || !sts_i.prio_ge) begin
            cmd_o.do_insert = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end else if (!sts_i.idx_end) begin
          if (sts_i.id_match) begin
            cmd_o.do_remove = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      pts_pkg::S_ENTRY: begin
        cmd_o.out_kind = pts_pkg::KIND_DISPATCH;
        if (sts_i.idx_end) begin
          cmd_o.set_started = (sts_i.req_cmd == pts_pkg::CMD_START);
        end else if (sts_i.req_cmd == pts_pkg::CMD_START) begin
          cmd_o.out_load = sts_i.out_free;
          cmd_o.idx_inc  = sts_i.out_free;
        end else if (sts_i.tick_hit) begin
          cmd_o.out_load    = sts_i.out_free;
          cmd_o.tick_update = sts_i.out_free;
          cmd_o.idx_inc     = sts_i.out_free;
        end else begin
          cmd_o.tick_update = 1'b1;
          cmd_o.idx_inc     = 1'b1;
        end
      end
      pts_pkg::S_FINAL: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = status_q;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // A table edit ends the search, so the next state must be the closing status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.do_insert || cmd_o.do_remove) |=> state_q == pts_pkg::S_FINAL)
    else $error("table edit not followed by the closing status");

  // The closing status leaves the controller idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::S_FINAL && cmd_o.out_load) |=> state_q == pts_pkg::S_IDLE)
    else $error("controller did not return to idle after the closing status");

  // A new item is only taken while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> state_q == pts_pkg::S_DECODE)
    else $error("request captured outside idle");

endmodule

// ===== hw/rtl/pts_dp.sv =====
module pts_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_pkg::req_t       in_data_i,
  input  logic                clear_i,
  input  pts_pkg::dp_cmd_t    cmd_i,
  output pts_pkg::dp_status_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pts_pkg::rsp_t       out_data_o
);

  pts_pkg::entry_t tbl_q [pts_pkg::MAX_TASKS];
  pts_pkg::entry_t tbl_d [pts_pkg::MAX_TASKS];
  pts_pkg::req_t   req_q;
  pts_pkg::rsp_t   out_q, out_d;
  pts_pkg::entry_t cur;
  pts_pkg::entry_t new_entry;

  logic [pts_pkg::CNT_W-1:0] count_q, count_d;
  logic [pts_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                      started_q, started_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;
  logic [15:0]               cnt_inc;

  assign cur      = tbl_q[idx_q[pts_pkg::IDX_W-1:0]];
  assign cnt_inc  = cur.counter + 16'd1;
  assign out_free = !out_valid_q || !out_stall_i;

  assign new_entry.id      = req_q.task_id;
  assign new_entry.period  = req_q.period;
  assign new_entry.counter = req_q.initial_count;
  assign new_entry.prio    = req_q.priority_req;

  always_comb begin
    sts_o.req_cmd    = req_q.cmd;
    sts_o.id_null    = (req_q.task_id == 8'd0);
    sts_o.count_zero = (count_q == '0);
    sts_o.full       = (count_q == pts_pkg::CNT_W'(pts_pkg::MAX_TASKS));
    sts_o.idx_end    = (idx_q >= count_q);
    sts_o.prio_ge    = (cur.prio >= req_q.priority_req);
    sts_o.id_match   = (cur.id == req_q.task_id);
    sts_o.tick_hit   = (cnt_inc == cur.period);
    sts_o.started    = started_q;
    sts_o.out_free   = out_free;
  end

  // Table row: slots shift on insert or remove, or one counter ticks.
  always_comb begin
    for (int j = 0; j < pts_pkg::MAX_TASKS; j++) begin
      tbl_d[j] = tbl_q[j];
      if (cmd_i.do_insert) begin
        if (pts_pkg::CNT_W'(j) == idx_q) begin
          tbl_d[j] = new_entry;
        end else if (j > 0 && pts_pkg::CNT_W'(j) > idx_q &&
                     pts_pkg::CNT_W'(j) <= count_q) begin
          tbl_d[j] = tbl_q[(j > 0) ? j - 1 : 0];
        end
      end else if (cmd_i.do_remove) begin
        if (pts_pkg::CNT_W'(j) >= idx_q && j < pts_pkg::MAX_TASKS - 1) begin
          tbl_d[j] = tbl_q[(j < pts_pkg::MAX_TASKS - 1) ? j + 1 : j];
        end
      end else if (cmd_i.tick_update && pts_pkg::CNT_W'(j) == idx_q) begin
        tbl_d[j].counter = (cnt_inc == tbl_q[j].period) ? 16'd0 : cnt_inc;
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    started_d   = started_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (clear_i) begin
      count_d   = '0;
      started_d = 1'b0;
    end else if (cmd_i.do_insert) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.do_remove) begin
      count_d = count_q - 1'b1;
    end
    if (cmd_i.set_started) begin
      started_d = 1'b1;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_d.kind  = cmd_i.out_kind;
      if (cmd_i.out_kind == pts_pkg::KIND_DISPATCH) begin
        out_d.task_id_out = cur.id;
        out_d.status      = pts_pkg::ST_OK;
        out_d.last        = 1'b0;
      end else begin
        out_d.task_id_out = 8'd0;
        out_d.status      = cmd_i.out_status;
        out_d.last        = 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      started_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      started_q   <= started_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_q <= tbl_d;
    out_q <= out_d;
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pts_pkg::CNT_W'(pts_pkg::MAX_TASKS))
    else $error("task count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |-> !sts_o.full && idx_q <= count_q)
    else $error("insert into a full table or past its end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_remove |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not shrink the table");

endmodule

// ===== hw/rtl/periodic_task_scheduler_core.sv =====
// Periodic task scheduler core.
// Commands arrive on the input channel (in_valid_i / in_stall_o / in_data_i) and
// every command produces one or more results on the output channel
// (out_valid_o / out_stall_i / out_data_o); the final result of a command is a
// status transfer with last set, preceded by one dispatch transfer per task
// dispatched by a start or tick. An APB-style port holds the enable register;
// writing 0 to it empties the task table and disarms the tick.
// Each command is captured in the request register while idle and then
// decoded; a command refused at decode, or a tick before start, goes on
// straight to its closing status. Create and delete first search the table
// up to the position they need. Start and tick walk the whole table one entry
// per cycle through a single read port, but an entry to be dispatched waits
// while the output register is held; its dispatch is loaded as it is visited.
// The next command is accepted as soon as the closing status is in the
// output register, so it may wait there while new work begins.
// When the receiver stalls, the output register holds its transfer and the
// scan waits at the next dispatch. Reset empties the table, clears the
// started flag and the enable register, and leaves the output channel idle.
module periodic_task_scheduler_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pts_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pts_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  pts_pkg::dp_cmd_t    dp_cmd;
  pts_pkg::dp_status_t dp_sts;

  logic enable_q, enable_d;
  logic reg_write;
  logic table_clear;

  // The only register decodes at paddr[2] == 0 (byte addresses 0 to 3); addresses 4 to 7 are ignored.
  assign pready      = 1'b1;
  assign reg_write   = psel && penable && pwrite && (paddr[2] == pts_pkg::REG_ENABLE);
  assign table_clear = reg_write && !pwdata[0];
  assign enable_d    = reg_write ? pwdata[0] : enable_q;
  assign prdata      = (paddr[2] == pts_pkg::REG_ENABLE) ? {31'd0, enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else begin
      enable_q <= enable_d;
    end
  end

  // The controller sequences each command; the datapath owns the table.
  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .enable_i   (enable_q),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  pts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .clear_i     (table_clear),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/sched_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port of the scheduler core, keeps
// its own copy of the task table and compares every result transfer with
// the oldest outstanding expectation.
module sched_checker
  import pts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          dispatch_count_o
);

  localparam int REPORT_LIMIT = 10;

  entry_t           task_table [MAX_TASKS];
  logic [CNT_W-1:0] task_count;
  logic             started_q;
  logic             enable_q;
  rsp_t             expected_q [$];
  int               fail_cnt;
  int               result_cnt;
  int               dispatch_cnt;

  function automatic void clear_table();
    for (int i = 0; i < MAX_TASKS; i++) task_table[i] = '0;
    task_count = '0;
    started_q  = 1'b0;
  endfunction

  function automatic void expect_dispatch(input logic [7:0] id);
    rsp_t res;
    res.kind        = KIND_DISPATCH;
    res.task_id_out = id;
    res.status      = ST_OK;
    res.last        = 1'b0;
    expected_q.push_back(res);
  endfunction

  // Applies one command to the table copy and queues the results it causes.
  function automatic void apply_command(input req_t r);
    status_e st;
    int      pos;
    rsp_t    res;
    st = ST_OK;
    case (r.cmd)
      CMD_CREATE: begin
        if (r.task_id == 8'd0) st = ST_NULL;
        else if (!enable_q) st = ST_DISABLED;
        else if (task_count >= MAX_TASKS) st = ST_FULL;
        else begin
          // Equal priorities go behind the ones already present.
          pos = 0;
          while (pos < task_count && task_table[pos].prio >= r.priority_req) pos++;
          for (int i = task_count; i > pos; i--) task_table[i] = task_table[i-1];
          task_table[pos].id      = r.task_id;
          task_table[pos].period  = r.period;
          task_table[pos].counter = r.initial_count;
          task_table[pos].prio    = r.priority_req;
          task_count++;
        end
      end
      CMD_DELETE: begin
        if (r.task_id == 8'd0) st = ST_NULL;
        else if (task_count == 0) st = ST_EMPTY;
        else begin
          pos = 0;
          while (pos < task_count && task_table[pos].id != r.task_id) pos++;
          if (pos >= task_count) st = ST_NOT_FOUND;
          else begin
            for (int i = pos; i + 1 < task_count; i++) task_table[i] = task_table[i+1];
            task_table[task_count-1] = '0;
            task_count--;
          end
        end
      end
      CMD_START: begin
        if (!enable_q) st = ST_DISABLED;
        else begin
          for (int i = 0; i < task_count; i++) expect_dispatch(task_table[i].id);
          started_q = 1'b1;
        end
      end
      default: begin
        if (started_q) begin
          for (int i = 0; i < task_count; i++) begin
            task_table[i].counter = task_table[i].counter + 16'd1;
            if (task_table[i].counter == task_table[i].period) begin
              expect_dispatch(task_table[i].id);
              task_table[i].counter = '0;
            end
          end
        end
      end
    endcase
    res.kind        = KIND_STATUS;
    res.task_id_out = 8'd0;
    res.status      = st;
    res.last        = 1'b1;
    expected_q.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_table();
      enable_q = 1'b0;
      expected_q.delete();
      fail_cnt     = 0;
      result_cnt   = 0;
      dispatch_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_ENABLE, 2'b00}) begin
        enable_q = pwdata[0];
        if (!pwdata[0]) clear_table();
      end
      if (out_valid_i && !out_stall_i) begin
        result_cnt++;
        if (out_data_i.kind == KIND_DISPATCH) dispatch_cnt++;
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: unexpected result kind=%0d id=%0d status=%0d last=%0d",
                     $time, out_data_i.kind, out_data_i.task_id_out,
                     out_data_i.status, out_data_i.last);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.kind !== want.kind || out_data_i.task_id_out !== want.task_id_out ||
              out_data_i.status !== want.status || out_data_i.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected kind=%0d id=%0d status=%0d last=%0d",
                       $time, want.kind, want.task_id_out, want.status, want.last);
              $display("%0t: mismatch, got      kind=%0d id=%0d status=%0d last=%0d",
                       $time, out_data_i.kind, out_data_i.task_id_out,
                       out_data_i.status, out_data_i.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
    end
    mismatch_count_o <= fail_cnt;
    pending_o        <= expected_q.size();
    result_count_o   <= result_cnt;
    dispatch_count_o <= dispatch_cnt;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Top of the scheduler bench. This module only produces stimulus on the
// command channel and the register port, plays the receiver on the result
// channel, and gives the verdict. All prediction and comparison is done by
// the checker instance that sits beside the core.
module tb;
  import pts_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off plus one table scan.
  localparam int STALL_LIMIT = 2000;
  // Length of the single long receiver hold-off.
  localparam int HOLD_CYCLES = 200;
  // Quiet cycles after the last result, to catch stray transfers.
  localparam int TAIL_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rsp_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_results;
  int result_count;
  int dispatch_count;
  int commands_sent;
  int reg_writes;

  // Burst flags switch the random idling off for a stretch of transfers.
  bit sender_burst;
  bit receiver_burst;
  // The stimulus requests the long hold-off; the receiver marks it as taken.
  bit hold_off_go;
  bit hold_done;

  periodic_task_scheduler_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  sched_checker u_sched_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results),
    .result_count_o  (result_count),
    .dispatch_count_o(dispatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Builds one command with explicit field values; every field comes from the
  // arguments, and the callers pass zero for fields a command does not use.
  function automatic req_t make_req(input cmd_e c, input logic [7:0] id,
                                    input logic [15:0] per, input logic [7:0] pri,
                                    input logic [15:0] cnt);
    req_t r;
    r.cmd           = c;
    r.task_id       = id;
    r.period        = per;
    r.priority_req  = pri;
    r.initial_count = cnt;
    return r;
  endfunction

  // Task ids come mostly from a small pool so that deletes find their
  // target and duplicates occur; now and then the null id or any id at all.
  function automatic logic [7:0] pick_task_id();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return 8'd0;
    else if (sel < 4) return 8'($urandom);
    else return 8'($urandom_range(1, 12));
  endfunction

  // Draws a command with the given percentages for create, delete and start;
  // the remainder are ticks. Three out of four commands carry narrow content
  // (small periods and counts, few priorities) so that ticks actually reach
  // their periods and ties occur. The rest keep full-width random fields.
  function automatic req_t random_request(input int create_pct, input int delete_pct,
                                          input int start_pct);
    req_t        r;
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom, $urandom};
    r    = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < create_pct) r.cmd = CMD_CREATE;
    else if (pick < create_pct + delete_pct) r.cmd = CMD_DELETE;
    else if (pick < create_pct + delete_pct + start_pct) r.cmd = CMD_START;
    else r.cmd = CMD_TICK;
    if ($urandom_range(0, 3) != 0) begin
      r.task_id       = pick_task_id();
      r.period        = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      r.priority_req  = 8'($urandom_range(0, 7));
      r.initial_count = 16'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Offers one command after a random gap and returns at the clock edge
  // where the transfer happens. No assignment is made in that time step,
  // so the next call may raise or lower valid without a conflict.
  task automatic send_request(input req_t r);
    int gap;
    if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    commands_sent++;
  endtask

  task automatic run_mix(input int count, input int create_pct, input int delete_pct,
                         input int start_pct);
    repeat (count) send_request(random_request(create_pct, delete_pct, start_pct));
  endtask

  // Stops offering commands and waits until every predicted result has been
  // transferred, which leaves the core idle for a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge. The bus
  // then idles before the task returns, so that back-to-back writes never drive
  // psel twice in the same time step.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Only bit 0 of the enable register matters, so the upper bits are random.
  task automatic set_enable(input bit en);
    reg_write({REG_ENABLE, 2'b00}, ($urandom() << 1) | 32'(en));
  endtask

  // Receiver: stalls a random number of cycles before each result, with
  // bursts of back-to-back transfers, and once takes a long hold-off so the
  // core fills up and pushes back on the command channel.
  initial begin
    int stall_cycles;
    out_stall_i <= 1'b1;
    receiver_burst = 1'b0;
    hold_done      = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      stall_cycles = receiver_burst ? 0 : $urandom_range(0, 3);
      if (hold_off_go && !hold_done) begin
        stall_cycles += HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: any transfer on either channel or the register port restarts
  // the count of quiet cycles.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results still outstanding",
             $time, STALL_LIMIT, pending_results);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    sender_burst  = 1'b0;
    hold_off_go   = 1'b0;
    commands_sent = 0;
    reg_writes    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The scheduler comes out of reset disabled: a create is
    // refused, although the null id is reported ahead of the disabled state,
    // a start is refused, and a tick before any start does nothing.
    send_request(make_req(CMD_CREATE, 8'd5, 16'd3, 8'd1, 16'd0));
    send_request(make_req(CMD_CREATE, 8'd0, 16'd3, 8'd1, 16'd0));
    send_request(make_req(CMD_START, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_TICK, 8'd0, 16'd0, 8'd0, 16'd0));
    // Deleting the null task, then deleting from the empty table.
    send_request(make_req(CMD_DELETE, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_DELETE, 8'd3, 16'd0, 8'd0, 16'd0));
    drain();
    set_enable(1'b1);

    // Field extremes: the top id, period and priority with a counter one
    // short of its period; a zero period whose counter wraps on the next
    // tick; and two tasks sharing id and priority to check creation order.
    send_request(make_req(CMD_CREATE, 8'd255, 16'hFFFF, 8'd255, 16'hFFFE));
    send_request(make_req(CMD_CREATE, 8'd1, 16'd0, 8'd0, 16'hFFFF));
    send_request(make_req(CMD_CREATE, 8'd7, 16'd1, 8'd128, 16'd0));
    send_request(make_req(CMD_CREATE, 8'd7, 16'd2, 8'd128, 16'd0));
    send_request(make_req(CMD_CREATE, 8'd0, 16'd1, 8'd9, 16'd0));
    send_request(make_req(CMD_TICK, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_START, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_TICK, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_TICK, 8'd0, 16'd0, 8'd0, 16'd0));
    drain();
    // A write to a register index that does not exist must leave the
    // scheduler enabled and the table intact.
    reg_write({~REG_ENABLE, 2'b00}, 32'd0);

    // The duplicate id loses only its first copy; an absent id is reported.
    send_request(make_req(CMD_DELETE, 8'd7, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_DELETE, 8'd99, 16'd0, 8'd0, 16'd0));
    // A task created after start joins the schedule; start again repeats
    // the full dispatch.
    send_request(make_req(CMD_CREATE, 8'd42, 16'd3, 8'd200, 16'd0));
    send_request(make_req(CMD_START, 8'd0, 16'd0, 8'd0, 16'd0));
    send_request(make_req(CMD_TICK, 8'd0, 16'd0, 8'd0, 16'd0));
    drain();

    // Fill from an empty table with non-null ids until the core reports the
    // table full, then start and tick with a full table.
    set_enable(1'b0);
    set_enable(1'b1);
    repeat (18) send_request(make_req(CMD_CREATE, 8'($urandom_range(1, 255)),
                                      16'($urandom_range(1, 4)), 8'($urandom),
                                      16'($urandom_range(0, 3))));
    send_request(make_req(CMD_START, 8'd0, 16'd0, 8'd0, 16'd0));
    run_mix(10, 0, 0, 0);

    // Mixed traffic; the receiver takes its long hold-off early in this
    // phase while commands keep coming, so the core stalls its input.
    hold_off_go = 1'b1;
    run_mix(50, 30, 25, 10);
    drain();

    // Disabled: the table is cleared and every command is refused or empty.
    set_enable(1'b0);
    run_mix(12, 30, 25, 15);
    drain();

    // Tick-heavy phase on a fresh table.
    set_enable(1'b1);
    run_mix(8, 100, 0, 0);
    send_request(make_req(CMD_START, 8'd0, 16'd0, 8'd0, 16'd0));
    run_mix(30, 10, 10, 5);
    drain();

    // Create-heavy traffic that grows the table toward full.
    set_enable(1'b0);
    set_enable(1'b1);
    run_mix(50, 40, 15, 10);
    drain();

    // Enabling again while already enabled must not clear anything.
    set_enable(1'b1);
    run_mix(25, 35, 20, 10);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d commands and %0d register writes, %0d results checked",
             commands_sent, reg_writes, result_count);
    $display("Summary: %0d task dispatches, including a full table and a long receiver hold-off",
             dispatch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
